// ----- src/pao_pkg.sv -----
// ----------------------------------------------------------------------------
// pao_pkg
// Shared types and codes of the page addressed display controller.
// ----------------------------------------------------------------------------
package pao_pkg;

	localparam int unsigned IDX_W       = 12;
	localparam int unsigned STORE_AW    = 11;
	localparam int unsigned CFG_IDX_W   = 1;
	localparam int unsigned CFG_W       = 8;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [1:0] MODE_CMD  = 2'd0;
	localparam logic [1:0] MODE_DATA = 2'd1;
	localparam logic [1:0] MODE_READ = 2'd2;
	localparam logic [1:0] MODE_NONE = 2'd3;

	localparam logic [7:0] CMD_DISPLAY_OFF    = 8'hAE;
	localparam logic [7:0] CMD_DISPLAY_ON     = 8'hAF;
	localparam logic [7:0] CMD_NORMAL         = 8'hA6;
	localparam logic [7:0] CMD_INVERT         = 8'hA7;
	localparam logic [7:0] CMD_PAGE_FIRST     = 8'hB0;
	localparam logic [7:0] CMD_PAGE_LAST      = 8'hB7;
	localparam logic [7:0] CMD_COL_LOW_LAST   = 8'h0F;
	localparam logic [7:0] CMD_COL_HIGH_FIRST = 8'h10;
	localparam logic [7:0] CMD_COL_HIGH_LAST  = 8'h1F;

	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLUMNS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS    = 1'b1;

	localparam logic [7:0] ACOLS_RESET = 8'd128;
	localparam logic [6:0] AROWS_RESET = 7'd64;

	typedef struct packed {
		logic                wr;
		logic                rd;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          data;
		logic [2:0]          bit_sel;
		logic                inv;
		logic                status;
	} req_t;

	typedef struct packed {
		logic                we;
		logic                re;
		logic [STORE_AW-1:0] addr;
		logic [7:0]          wdata;
	} ram_req_t;

endpackage

// ----- src/pao_ram.sv -----
// ----------------------------------------------------------------------------
// pao_ram
// Single port RAM with registered read data.
// ----------------------------------------------------------------------------
module pao_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024,
	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- src/pao_queue.sv -----
// ----------------------------------------------------------------------------
// pao_queue
// Short request queue between the decode front and the frame store back.
// ----------------------------------------------------------------------------
module pao_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  pao_pkg::req_t  push_req,
	output logic           full,
	input  logic           pop,
	output logic           head_valid,
	output pao_pkg::req_t  head_req
);
	import pao_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

	req_t             entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full       = (count_q == CNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_req   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// ----- src/pao_front.sv -----
// ----------------------------------------------------------------------------
// pao_front
// Accepts requests, decodes commands, tracks the page and column pointers,
// range checks writes and pixel reads and forms frame store requests.
// ----------------------------------------------------------------------------
module pao_front #(
	parameter int unsigned MAX_COLUMNS = 128,
	parameter int unsigned PAGE_COUNT  = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pao_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pao_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            accept,
	input  logic [1:0]                      mode,
	input  logic [7:0]                      value,
	input  logic [6:0]                      pixel_x,
	input  logic [5:0]                      pixel_y,
	output pao_pkg::req_t                   req
);
	import pao_pkg::*;

	localparam logic [IDX_W-1:0] STORE_BYTES = IDX_W'(MAX_COLUMNS * PAGE_COUNT);
	localparam logic [3:0]       PAGES       = 4'(PAGE_COUNT);

	logic [7:0] acols_q;
	logic [6:0] arows_q;
	logic       disp_q;
	logic       inv_q;
	logic [2:0] page_q;
	logic [7:0] col_q;

	logic             disp_nxt;
	logic             inv_nxt;
	logic [2:0]       page_nxt;
	logic [7:0]       col_nxt;
	logic [IDX_W-1:0] wr_idx;
	logic [IDX_W-1:0] wr_limit;
	logic             wr_ok;
	logic [7:0]       col_inc;
	logic [3:0]       page_inc;
	logic [2:0]       rd_page;
	logic [IDX_W-1:0] rd_idx;
	logic             rd_ok;

	always_comb begin
		wr_idx   = IDX_W'(page_q) * IDX_W'(acols_q) + IDX_W'(col_q);
		wr_limit = IDX_W'(acols_q) * IDX_W'(PAGE_COUNT);
		wr_ok    = (wr_idx < wr_limit) && (wr_idx < STORE_BYTES);
		col_inc  = col_q + 8'd1;
		page_inc = {1'b0, page_q} + 4'd1;

		rd_page = pixel_y[5:3];
		rd_idx  = IDX_W'(pixel_x) + IDX_W'(rd_page) * IDX_W'(acols_q);
		rd_ok   = ({1'b0, pixel_x} < acols_q) && ({1'b0, pixel_y} < arows_q)
			&& ({1'b0, rd_page} < PAGES) && (rd_idx < STORE_BYTES);

		disp_nxt = disp_q;
		inv_nxt  = inv_q;
		page_nxt = page_q;
		col_nxt  = col_q;

		req         = '0;
		req.data    = value;
		req.bit_sel = pixel_y[2:0];
		req.inv     = inv_q;

		unique case (mode)
			MODE_CMD: begin
				priority if (value == CMD_DISPLAY_OFF) begin
					disp_nxt = 1'b0;
				end else if (value == CMD_DISPLAY_ON) begin
					disp_nxt = 1'b1;
				end else if (value == CMD_NORMAL) begin
					inv_nxt = 1'b0;
				end else if (value == CMD_INVERT) begin
					inv_nxt = 1'b1;
				end else if (value >= CMD_PAGE_FIRST && value <= CMD_PAGE_LAST) begin
					page_nxt = value[2:0];
				end else if (value <= CMD_COL_LOW_LAST) begin
					col_nxt = {col_q[7:4], value[3:0]};
				end else if (value >= CMD_COL_HIGH_FIRST && value <= CMD_COL_HIGH_LAST) begin
					col_nxt = {value[3:0], col_q[3:0]};
				end else begin
					disp_nxt = disp_q;
				end
			end
			MODE_DATA: begin
				req.wr     = wr_ok;
				req.addr   = wr_idx[STORE_AW-1:0];
				req.status = !wr_ok;
				if (wr_ok) begin
					if (col_inc >= acols_q) begin
						col_nxt  = 8'd0;
						page_nxt = (page_inc >= PAGES) ? 3'd0 : page_inc[2:0];
					end else begin
						col_nxt = col_inc;
					end
				end
			end
			MODE_READ: begin
				req.rd     = rd_ok && disp_q;
				req.addr   = rd_idx[STORE_AW-1:0];
				req.status = !rd_ok;
			end
			MODE_NONE: begin
				req.status = 1'b0;
			end
			default: begin
				req.status = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acols_q <= ACOLS_RESET;
			arows_q <= AROWS_RESET;
			disp_q  <= 1'b1;
			inv_q   <= 1'b0;
			page_q  <= 3'd0;
			col_q   <= 8'd0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ACTIVE_COLUMNS: acols_q <= cfg_data;
					REG_ACTIVE_ROWS:    arows_q <= cfg_data[6:0];
					default:            acols_q <= acols_q;
				endcase
			end
			if (accept) begin
				disp_q <= disp_nxt;
				inv_q  <= inv_nxt;
				page_q <= page_nxt;
				col_q  <= col_nxt;
			end
		end
	end

endmodule

// ----- src/pao_back.sv -----
// ----------------------------------------------------------------------------
// pao_back
// Clears the frame store after reset, then carries out queued writes and
// pixel reads and holds the result in the output register.
// ----------------------------------------------------------------------------
module pao_back #(
	parameter int unsigned MAX_COLUMNS = 128,
	parameter int unsigned PAGE_COUNT  = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  pao_pkg::req_t     head_req,
	output logic              pop,
	output logic              clr_busy,
	output pao_pkg::ram_req_t ram_req,
	input  logic [7:0]        ram_rdata,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              status,
	output logic              pixel_lit
);
	import pao_pkg::*;

	localparam int unsigned DEPTH = MAX_COLUMNS * PAGE_COUNT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic          clr_busy_q;
	logic [AW-1:0] clr_addr_q;
	logic          vld_s1;
	req_t          req_s1;
	logic          out_valid_q;
	logic          status_q;
	logic          pixel_q;
	logic          adv;

	assign adv      = vld_s1 && (!out_valid_q || out_ready);
	assign pop      = head_valid && !clr_busy_q && (!vld_s1 || adv);
	assign clr_busy = clr_busy_q;

	always_comb begin
		if (clr_busy_q) begin
			ram_req.we    = 1'b1;
			ram_req.re    = 1'b0;
			ram_req.addr  = STORE_AW'(clr_addr_q);
			ram_req.wdata = 8'd0;
		end else begin
			ram_req.we    = pop && head_req.wr;
			ram_req.re    = pop && head_req.rd;
			ram_req.addr  = head_req.addr;
			ram_req.wdata = head_req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			req_s1 <= head_req;
		end
		if (adv) begin
			status_q <= req_s1.status;
			pixel_q  <= req_s1.rd && (ram_rdata[req_s1.bit_sel] ^ req_s1.inv);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q  <= 1'b1;
			clr_addr_q  <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_addr_q <= clr_addr_q + 1'b1;
				if (clr_addr_q == AW'(DEPTH - 1)) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (pop) begin
				vld_s1 <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign pixel_lit = pixel_q;

endmodule

// ----- src/page_addressed_oled_controller.sv -----
// ----------------------------------------------------------------------------
// page_addressed_oled_controller
// Page addressed monochrome display controller with a byte wide frame store.
//
//   channel  signals                               moves
//   in       in_valid in_ready mode value          one request
//            pixel_x pixel_y
//   out      out_valid out_ready status pixel_lit  one result per request
//   cfg      cfg_we cfg_index cfg_data             register write
//
// One request per cycle sustained while out_ready stays high, bound by the
// single frame store port. Each request passes the queue, the read stage and
// the output register. After reset the frame store is cleared one byte a
// cycle, all MAX_COLUMNS * PAGE_COUNT bytes (1024 at the defaults), with
// in_ready low meanwhile. A stalled output fills a two entry queue before
// in_ready drops.
module page_addressed_oled_controller #(
	parameter int unsigned MAX_COLUMNS = 128,
	parameter int unsigned PAGE_COUNT  = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pao_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pao_pkg::CFG_W-1:0]     cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    mode,
	input  logic [7:0]                    value,
	input  logic [6:0]                    pixel_x,
	input  logic [5:0]                    pixel_y,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          status,
	output logic                          pixel_lit
);
	import pao_pkg::*;

	localparam int unsigned DEPTH = MAX_COLUMNS * PAGE_COUNT;
	localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	req_t     front_req;
	req_t     head_req;
	ram_req_t ram_req;
	logic     q_full;
	logic     q_valid;
	logic     pop;
	logic     clr_busy;
	logic     accept;
	logic [7:0] ram_rdata;

	assign in_ready = !clr_busy && !q_full;
	assign accept   = in_valid && in_ready;

	pao_front #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.PAGE_COUNT (PAGE_COUNT)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.accept   (accept),
		.mode     (mode),
		.value    (value),
		.pixel_x  (pixel_x),
		.pixel_y  (pixel_y),
		.req      (front_req)
	);

	pao_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_req  (front_req),
		.full      (q_full),
		.pop       (pop),
		.head_valid(q_valid),
		.head_req  (head_req)
	);

	pao_back #(
		.MAX_COLUMNS(MAX_COLUMNS),
		.PAGE_COUNT (PAGE_COUNT)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_valid(q_valid),
		.head_req  (head_req),
		.pop       (pop),
		.clr_busy  (clr_busy),
		.ram_req   (ram_req),
		.ram_rdata (ram_rdata),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.pixel_lit (pixel_lit)
	);

	pao_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_req.we),
		.re   (ram_req.re),
		.addr (ram_req.addr[AW-1:0]),
		.wdata(ram_req.wdata),
		.rdata(ram_rdata)
	);

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_req.we && ram_req.re))
		else $error("frame store written and read in one cycle");

	a_clear_empty: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy |-> (!q_valid && !pop))
		else $error("request queued during frame store clear");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(clr_busy) |-> $past(ram_req.we))
		else $error("frame store clear ended without a write");

endmodule

// ----- tb/page_addressed_oled_checker.sv -----
// ----------------------------------------------------------------------------
// page_addressed_oled_checker
// Watches the request, result and register ports of the display controller.
// Keeps its own copy of the pointers, polarity, geometry and frame store,
// works out the result of every request taken, and compares each result
// that leaves the block with the oldest one still due.
// ----------------------------------------------------------------------------
module page_addressed_oled_checker
	import pao_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [1:0]           mode,
	input  logic [7:0]           value,
	input  logic [6:0]           pixel_x,
	input  logic [5:0]           pixel_y,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic                 status,
	input  logic                 pixel_lit,
	output int                   awaiting,
	output int                   error_count
);

	localparam int unsigned PAGES       = 8;
	localparam int unsigned STORE_BYTES = 128 * PAGES;

	typedef struct packed {
		logic status;
		logic pixel_lit;
	} shown_t;

	shown_t     due_results[$];
	logic [7:0] columns;
	logic [6:0] rows;
	logic       disp_on;
	logic       inverted;
	logic [2:0] page;
	logic [7:0] column;
	logic [7:0] frame [0:STORE_BYTES-1];
	int         fails;

	function automatic shown_t panel_response(logic [1:0] m, logic [7:0] v,
			logic [6:0] x, logic [5:0] y);
		shown_t      r;
		int unsigned idx;
		int unsigned pg;
		r = '0;
		case (m)
			MODE_CMD: begin
				if (v == CMD_DISPLAY_OFF) disp_on = 1'b0;
				else if (v == CMD_DISPLAY_ON) disp_on = 1'b1;
				else if (v == CMD_NORMAL) inverted = 1'b0;
				else if (v == CMD_INVERT) inverted = 1'b1;
				else if (v >= CMD_PAGE_FIRST && v <= CMD_PAGE_LAST) page = v[2:0];
				else if (v <= CMD_COL_LOW_LAST) column[3:0] = v[3:0];
				else if (v >= CMD_COL_HIGH_FIRST && v <= CMD_COL_HIGH_LAST) column[7:4] = v[3:0];
			end
			MODE_DATA: begin
				idx = 32'(page) * 32'(columns) + 32'(column);
				if (idx >= 32'(columns) * PAGES || idx >= STORE_BYTES) begin
					r.status = 1'b1;
				end else begin
					frame[idx] = v;
					column = column + 8'd1;
					if (column >= columns) begin
						column = 8'd0;
						page = page + 3'd1;
					end
				end
			end
			MODE_READ: begin
				pg = 32'(y) / 8;
				if (x >= columns || y >= rows || pg >= PAGES) begin
					r.status = 1'b1;
				end else begin
					idx = 32'(x) + pg * 32'(columns);
					if (idx >= STORE_BYTES) r.status = 1'b1;
					else r.pixel_lit = (frame[idx][y[2:0]] ^ inverted) & disp_on;
				end
			end
			default: ;
		endcase
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		shown_t want;
		if (!arst_n) begin
			columns = ACOLS_RESET;
			rows = AROWS_RESET;
			disp_on = 1'b1;
			inverted = 1'b0;
			page = '0;
			column = '0;
			for (int i = 0; i < STORE_BYTES; i++) frame[i] = '0;
			due_results.delete();
			fails = 0;
			awaiting <= 0;
			error_count <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_results.size() == 0) begin
					$display("%0t: result with no request waiting, status %0d pixel_lit %0d",
						$time, status, pixel_lit);
					fails++;
				end else begin
					want = due_results.pop_front();
					if (status !== want.status) begin
						$display("%0t: status expected %0d, actual %0d", $time, want.status, status);
						fails++;
					end
					if (pixel_lit !== want.pixel_lit) begin
						$display("%0t: pixel_lit expected %0d, actual %0d",
							$time, want.pixel_lit, pixel_lit);
						fails++;
					end
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_ACTIVE_COLUMNS: columns = cfg_data;
					REG_ACTIVE_ROWS:    rows = cfg_data[6:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				due_results.push_back(panel_response(mode, value, pixel_x, pixel_y));
			awaiting <= due_results.size();
			error_count <= fails;
		end
	end

endmodule

// ----- tb/page_addressed_oled_controller_test.sv -----
// ----------------------------------------------------------------------------
// page_addressed_oled_controller_test
// Drives the display controller with a short directed sequence and then
// phases of random commands, positioned data bursts and pixel reads under
// several geometries, with random stalls on both sides and one long stall
// of the result side. The checker beside the block does the comparing.
// ----------------------------------------------------------------------------
module page_addressed_oled_controller_test;
	import pao_pkg::*;

	localparam int         RUN_LIMIT         = 200000;
	localparam int         PHASES            = 6;
	localparam logic [7:0] CMD_COL_LOW_FIRST = 8'h00;

	localparam logic [7:0] PHASE_COLS  [PHASES] = '{8'd128, 8'd1, 8'd255, 8'd64, 8'd0, 8'd16};
	localparam logic [6:0] PHASE_ROWS  [PHASES] = '{7'd64, 7'd1, 7'd127, 7'd40, 7'd0, 7'd8};
	localparam int         PHASE_ITEMS [PHASES] = '{120, 100, 100, 120, 40, 120};

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data  = '0;
	logic                 in_valid  = 1'b0;
	logic [1:0]           mode      = '0;
	logic [7:0]           value     = '0;
	logic [6:0]           pixel_x   = '0;
	logic [5:0]           pixel_y   = '0;
	logic                 out_ready = 1'b0;
	logic                 in_ready;
	logic                 out_valid;
	logic                 status;
	logic                 pixel_lit;
	int                   awaiting;
	int                   error_count;

	int         hold_ticks  = 0;
	bit         steady      = 1'b0;
	logic [7:0] geo_columns = ACOLS_RESET;
	logic [6:0] geo_rows    = AROWS_RESET;

	always #1 clk = ~clk;

	page_addressed_oled_controller dut (.*);

	page_addressed_oled_checker watch (.*);

	task automatic send_request(logic [1:0] m, logic [7:0] v, logic [6:0] x, logic [5:0] y);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= v;
		pixel_x <= x;
		pixel_y <= y;
		do @(posedge clk); while (!in_ready);
	endtask

	// hold requests back until every result is out
	task automatic settle();
		in_valid <= 1'b0;
		repeat (2) @(posedge clk);
		while (awaiting != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_geometry(logic [7:0] cols, logic [6:0] nrows);
		cfg_we <= 1'b1;
		cfg_index <= REG_ACTIVE_COLUMNS;
		cfg_data <= cols;
		@(posedge clk);
		cfg_index <= REG_ACTIVE_ROWS;
		cfg_data <= {1'($urandom), nrows};
		@(posedge clk);
		cfg_we <= 1'b0;
		geo_columns = cols;
		geo_rows = nrows;
	endtask

	task automatic random_phase(int count);
		int         sent;
		int         next_toggle;
		int         burst;
		int         pick;
		logic [7:0] col;
		logic [7:0] v;
		logic [6:0] x;
		logic [5:0] y;
		sent = 0;
		next_toggle = 0;
		while (sent < count) begin
			if (sent >= next_toggle) begin
				steady = ($urandom_range(0, 3) == 0);
				next_toggle = sent + 20;
			end
			if ($urandom_range(0, 2) == 0) begin
				// position the pointer, write a run of bytes, then read as many random pixels
				col = (geo_columns > 0) ? 8'($urandom_range(0, geo_columns - 1)) : 8'($urandom);
				burst = $urandom_range(1, 8);
				send_request(MODE_CMD, CMD_PAGE_FIRST | 8'($urandom_range(0, 7)), 7'($urandom),
					6'($urandom));
				send_request(MODE_CMD, CMD_COL_LOW_FIRST | {4'd0, col[3:0]}, 7'($urandom),
					6'($urandom));
				send_request(MODE_CMD, CMD_COL_HIGH_FIRST | {4'd0, col[7:4]}, 7'($urandom),
					6'($urandom));
				repeat (burst) send_request(MODE_DATA, 8'($urandom), 7'($urandom), 6'($urandom));
				repeat (burst) begin
					x = 7'($urandom);
					y = 6'($urandom);
					if (geo_columns > 0)
						x = 7'($urandom_range(0, (geo_columns > 128 ? 128 : geo_columns) - 1));
					if (geo_rows > 0 && $urandom_range(0, 3) != 0)
						y = 6'($urandom_range(0, (geo_rows > 64 ? 64 : geo_rows) - 1));
					send_request(MODE_READ, 8'($urandom), x, y);
				end
				sent += 3 + 2 * burst;
			end else begin
				x = 7'($urandom);
				y = 6'($urandom);
				v = 8'($urandom);
				if (geo_columns > 0 && $urandom_range(0, 3) != 0)
					x = 7'($urandom_range(0, (geo_columns > 128 ? 128 : geo_columns) - 1));
				if (geo_rows > 0 && $urandom_range(0, 3) != 0)
					y = 6'($urandom_range(0, (geo_rows > 64 ? 64 : geo_rows) - 1));
				pick = $urandom_range(0, 15);
				if (pick <= 5) begin
					send_request(MODE_DATA, v, x, y);
				end else if (pick <= 10) begin
					send_request(MODE_READ, v, x, y);
				end else if (pick == 11) begin
					case ($urandom_range(0, 7))
						0:       v = CMD_DISPLAY_OFF;
						1, 2:    v = CMD_DISPLAY_ON;
						3:       v = CMD_NORMAL;
						4:       v = CMD_INVERT;
						default: ;
					endcase
					send_request(MODE_CMD, v, x, y);
				end else if (pick == 12) begin
					send_request(MODE_CMD, CMD_PAGE_FIRST | 8'($urandom_range(0, 7)), x, y);
				end else if (pick <= 14) begin
					send_request(MODE_CMD, 8'($urandom_range(0, 31)), x, y);
				end else begin
					send_request(2'($urandom), v, x, y);
				end
				sent++;
			end
		end
		steady = 1'b0;
	endtask

	initial begin : result_sink
		int wait_ticks;
		bit held;
		held = 1'b0;
		forever begin
			if (hold_ticks > 0 && !held) begin
				out_ready <= 1'b0;
				repeat (hold_ticks) @(posedge clk);
				held = 1'b1;
			end
			wait_ticks = steady ? 0 : $urandom_range(0, 3);
			if (wait_ticks > 0) begin
				out_ready <= 1'b0;
				repeat (wait_ticks) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	initial begin : watchdog
		repeat (RUN_LIMIT) @(posedge clk);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		send_request(MODE_READ, 8'h00, 7'd0, 6'd0);
		send_request(MODE_DATA, 8'hFF, 7'd0, 6'd0);
		send_request(MODE_DATA, 8'h01, 7'd0, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd0, 6'd7);
		send_request(MODE_READ, 8'h00, 7'd1, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd1, 6'd1);
		send_request(MODE_CMD, CMD_INVERT, 7'd0, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd1, 6'd1);
		send_request(MODE_CMD, CMD_NORMAL, 7'd0, 6'd0);
		send_request(MODE_CMD, CMD_DISPLAY_OFF, 7'd0, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd0, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd127, 6'd63);
		send_request(MODE_CMD, CMD_DISPLAY_ON, 7'd0, 6'd0);
		// column pointer past the store: write rejected
		send_request(MODE_CMD, CMD_PAGE_LAST, 7'd0, 6'd0);
		send_request(MODE_CMD, CMD_COL_LOW_LAST, 7'd0, 6'd0);
		send_request(MODE_CMD, CMD_COL_HIGH_LAST, 7'd0, 6'd0);
		send_request(MODE_DATA, 8'h00, 7'd0, 6'd0);
		// last byte of the store, then wrap to the first
		send_request(MODE_CMD, CMD_COL_HIGH_FIRST | 8'h07, 7'd0, 6'd0);
		send_request(MODE_DATA, 8'hA5, 7'd0, 6'd0);
		send_request(MODE_DATA, 8'h5A, 7'd0, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd127, 6'd63);
		send_request(MODE_CMD, 8'h55, 7'd127, 6'd63);
		send_request(MODE_NONE, 8'hFF, 7'd127, 6'd63);
		send_request(MODE_CMD, CMD_COL_LOW_FIRST, 7'd0, 6'd0);
		send_request(MODE_READ, 8'h00, 7'd0, 6'd1);
		settle();

		for (int ph = 0; ph < PHASES; ph++) begin
			set_geometry(PHASE_COLS[ph], PHASE_ROWS[ph]);
			if (ph == 3) hold_ticks = 120;
			random_phase(PHASE_ITEMS[ph]);
			settle();
		end

		if (error_count == 0 && awaiting == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
